/* sv/r1fp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r1fp_pkg
// Shared types and codes of the rank-one flip pair finder.
// ----------------------------------------------------------------------------
package r1fp_pkg;

  localparam int MASK_W      = 64;
  localparam int IDX_FIELD_W = 6;
  localparam int MATCH_W     = 5;
  localparam int STATUS_W    = 3;

  localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Input item: one command plus the five factor masks of a tensor.
  typedef struct packed {
    logic              func;
    logic [MASK_W-1:0] first_left;
    logic [MASK_W-1:0] first_right;
    logic [MASK_W-1:0] second_left;
    logic [MASK_W-1:0] second_right;
    logic [MASK_W-1:0] product_mask;
  } in_t;

  // Stored tensor, one memory word.
  typedef struct packed {
    logic [MASK_W-1:0] first_left;
    logic [MASK_W-1:0] first_right;
    logic [MASK_W-1:0] second_left;
    logic [MASK_W-1:0] second_right;
    logic [MASK_W-1:0] product_mask;
  } tensor_t;

  // Result item.
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] earlier_index;
    logic [IDX_FIELD_W-1:0] new_index;
    logic [MATCH_W-1:0]     match_mask;
    logic [STATUS_W-1:0]    status;
    logic                   last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                clear;
    logic                short_vld;
    logic [STATUS_W-1:0] short_status;
    logic                cap;
    logic                rd_en;
    logic                wr_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic is_zero;
    logic is_full;
    logic walk_done;
  } stat_t;

endpackage : r1fp_pkg
`default_nettype wire

/* sv/r1fp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r1fp_ctrl
// Sequencer that decides each item and steps the table walk.
// ----------------------------------------------------------------------------
module r1fp_ctrl import r1fp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.short_status = ST_CLEARED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (stat.is_clear) begin
            cmd.clear        = 1'b1;
            cmd.short_vld    = 1'b1;
            cmd.short_status = ST_CLEARED;
          end else if (stat.is_zero) begin
            cmd.short_vld    = 1'b1;
            cmd.short_status = ST_DROPPED;
          end else if (stat.is_full) begin
            cmd.short_vld    = 1'b1;
            cmd.short_status = ST_FULL;
          end else begin
            cmd.cap   = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule : r1fp_ctrl
`default_nettype wire

/* sv/r1fp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// r1fp_dp
// Tensor memory, walk pointer, flip comparator and result register.
// ----------------------------------------------------------------------------
module r1fp_dp import r1fp_pkg::*; #(
  parameter int MAX_TENSORS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_item,
  input  wire cmd_t cmd,
  output stat_t     stat,
  output logic      out_valid,
  output out_t      out_item
);

  localparam int IDX_W = $clog2(MAX_TENSORS);
  localparam int CNT_W = $clog2(MAX_TENSORS + 1);

  tensor_t mem [MAX_TENSORS];

  tensor_t            cur_r;
  tensor_t            rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;
  logic [MATCH_W-1:0] match;

  assign stat.is_clear  = !in_item.func;
  assign stat.is_zero   = ((in_item.first_left == '0) && (in_item.first_right == '0)) ||
                          ((in_item.second_left == '0) && (in_item.second_right == '0)) ||
                          (in_item.product_mask == '0);
  assign stat.is_full   = (count_r >= CNT_W'(MAX_TENSORS));
  assign stat.walk_done = (ptr_r == count_r);

  // Flip partners of the entry read last cycle against the captured tensor.
  always_comb begin
    match[0] = (rd_data_r.first_left == cur_r.first_left) &&
               (rd_data_r.first_right == cur_r.first_right);
    match[1] = (rd_data_r.first_left == cur_r.second_left) &&
               (rd_data_r.first_right == cur_r.second_right);
    match[2] = (rd_data_r.second_left == cur_r.first_left) &&
               (rd_data_r.second_right == cur_r.first_right);
    match[3] = (rd_data_r.second_left == cur_r.second_left) &&
               (rd_data_r.second_right == cur_r.second_right);
    match[4] = (rd_data_r.product_mask == cur_r.product_mask);
  end

  always_comb begin
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    rd_vld_nxt    = cmd.rd_en;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    if (cmd.cap) begin
      ptr_nxt = '0;
    end
    if (cmd.rd_en) begin
      ptr_nxt = ptr_r + 1'b1;
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.short_vld) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = cmd.short_status;
      out_nxt.last   = 1'b1;
    end else if (rd_vld_r && (match != '0)) begin
      out_valid_nxt         = 1'b1;
      out_nxt.earlier_index = IDX_FIELD_W'(rd_idx_r);
      out_nxt.new_index     = IDX_FIELD_W'(count_r[IDX_W-1:0]);
      out_nxt.match_mask    = match;
      out_nxt.status        = ST_MATCH;
    end else if (cmd.wr_en) begin
      out_valid_nxt     = 1'b1;
      out_nxt.new_index = IDX_FIELD_W'(count_r[IDX_W-1:0]);
      out_nxt.status    = ST_ADDED;
      out_nxt.last      = 1'b1;
      count_nxt         = count_r + 1'b1;
    end
  end

  // Single port memory: the walk reads, the final step writes.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count_r[IDX_W-1:0]] <= cur_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
      rd_idx_r  <= ptr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur_r.first_left   <= in_item.first_left;
      cur_r.first_right  <= in_item.first_right;
      cur_r.second_left  <= in_item.second_left;
      cur_r.second_right <= in_item.second_right;
      cur_r.product_mask <= in_item.product_mask;
    end
    ptr_r <= ptr_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule : r1fp_dp
`default_nettype wire

/* sv/rank1_flip_pair_finder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rank1_flip_pair_finder
// Table of rank-one tensors that reports flip partners of each added tensor.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                      Handshake
//   -------  -------------------------  ------------------------------------
//   input    start, busy, in_item       item taken when start && !busy
//   result   out_valid, out_item        item shown for one cycle per strobe
//
// A clear, a dropped add and a rejected add each give their single result in
// the next cycle while busy stays low, so such items can follow each other in
// every cycle. An add that is stored holds busy while the walk through the
// tensor memory reads one entry per cycle from its single port and while the
// new tensor is then written, so no new item is taken until the add is done.
// Reset empties the table; the memory contents are not cleared, since only
// entries below the fill count are ever read. The receiver cannot stall, so
// every result leaves from the output register in the cycle after it forms.
//
// Each match result names the stored tensor and the index the new tensor
// will take; the summary result with status added and last set closes the
// sequence of an add.
// ----------------------------------------------------------------------------
module rank1_flip_pair_finder import r1fp_pkg::*; #(
  parameter int MAX_TENSORS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sees start only while idle, where busy is low.
  r1fp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the table, walks it and forms every result.
  r1fp_dp #(
    .MAX_TENSORS (MAX_TENSORS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule : rank1_flip_pair_finder
`default_nettype wire
